@@ hdl/cff_pkg.sv @@
// Package for the calorimeter fiducial filter: shared types, codes and constant tables.
// Used by cff_ctrl, cff_datapath and calorimeter_fiducial_filter; depends on nothing.
`default_nettype none
package cff_pkg;

   localparam int NUM_LAYERS_DEF  = 3;
   localparam int NUM_SECTORS_DEF = 6;
   localparam int MAX_LAYERS      = 3;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_DATA_W = 2;

   // Register indexes of the configuration port.
   localparam logic CSR_EXCL_MODE = 1'b0;
   localparam logic CSR_EDGE_EN   = 1'b1;

   typedef enum logic [2:0] {
      CAUSE_NONE     = 3'd0,
      CAUSE_MISSING  = 3'd1,
      CAUSE_LOW_VW   = 3'd2,
      CAUSE_EXCLUDED = 3'd3,
      CAUSE_EDGE     = 3'd4
   } cause_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam logic [3:0] LAST_STEP = 4'd11;

   typedef struct packed {
      logic       load;
      logic       calc;
      logic [3:0] step;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic need_edge;
      logic item_end;
      logic slot_free;
   } status_type;

   localparam logic [12:0] LOW_VW_LIMIT = 13'd144;

   typedef struct packed {
      logic [3:0]  modes;
      logic [1:0]  layer;
      logic [2:0]  sector;
      logic [1:0]  coord;
      logic [12:0] lo;
      logic [12:0] hi;
   } excl_type;

   localparam int EXCL_COUNT = 18;
   localparam excl_type EXCL_TABLE [EXCL_COUNT] = '{
      '{4'h6, 2'd0, 3'd1, 2'd2, 13'd1152, 13'd1512},
      '{4'h6, 2'd0, 3'd1, 2'd2, 13'd3528, 13'd3744},
      '{4'h6, 2'd0, 3'd2, 2'd1, 13'd1584, 13'd1872},
      '{4'h4, 2'd0, 3'd2, 2'd1, 13'd504,  13'd792},
      '{4'h6, 2'd0, 3'd3, 2'd2, 13'd5544, 13'd6048},
      '{4'h6, 2'd0, 3'd4, 2'd2, 13'd0,    13'd216},
      '{4'h6, 2'd0, 3'd4, 2'd1, 13'd3672, 13'd3888},
      '{4'h6, 2'd0, 3'd6, 2'd2, 13'd2664, 13'd3096},
      '{4'h6, 2'd1, 3'd1, 2'd1, 13'd1080, 13'd1512},
      '{4'h6, 2'd1, 3'd5, 2'd1, 13'd0,    13'd376},
      '{4'h6, 2'd2, 3'd1, 2'd1, 13'd0,    13'd648},
      '{4'h6, 2'd2, 3'd5, 2'd0, 13'd3096, 13'd3456},
      '{4'h8, 2'd0, 3'd1, 2'd2, 13'd1152, 13'd1512},
      '{4'h8, 2'd0, 3'd1, 2'd2, 13'd3312, 13'd3744},
      '{4'h8, 2'd0, 3'd2, 2'd1, 13'd1584, 13'd1800},
      '{4'h8, 2'd0, 3'd3, 2'd1, 13'd5544, 13'd6120},
      '{4'h8, 2'd0, 3'd4, 2'd1, 13'd3672, 13'd3888},
      '{4'h8, 2'd0, 3'd6, 2'd2, 13'd2736, 13'd3096}
   };

   // Rotation into the sector-1 frame, cos and sin scaled by 2^14.
   localparam logic signed [15:0] ROT_COS [6] = '{16'sd16384, 16'sd8192, -16'sd8192,
                                                  -16'sd16384, -16'sd8192, 16'sd8192};
   localparam logic signed [15:0] ROT_SIN [6] = '{16'sd0, -16'sd14189, -16'sd14189,
                                                  16'sd0, 16'sd14189, 16'sd14189};
   localparam logic [6:0] P_SPLIT [6] = '{7'd87, 7'd82, 7'd85, 7'd77, 7'd78, 7'd82};
   localparam logic [19:0] T_LEFT  [6] = '{20'd587356, 20'd628204, 20'd622296,
                                           20'd537756, 20'd582888, 20'd545822};
   localparam logic [19:0] T_RIGHT [6] = '{20'd587477, 20'd512589, 20'd592357,
                                           20'd562415, 20'd608219, 20'd498914};
   localparam logic [19:0] R_LEFT  [6] = '{20'd649348, 20'd647541, 20'd678320,
                                           20'd559324, 20'd559225, 20'd600997};
   localparam logic [19:0] R_RIGHT [6] = '{20'd654240, 20'd546992, 20'd636628,
                                           20'd578931, 20'd565367, 20'd564641};
   localparam logic signed [20:0] S_LEFT  [6] = '{21'sd582053, 21'sd544976, 21'sd549788,
                                                  21'sd568990, 21'sd564140, 21'sd573430};
   localparam logic signed [20:0] S_RIGHT [6] = '{-21'sd591876, -21'sd562926, -21'sd562246,
                                                  -21'sd563726, -21'sd568902, -21'sd550729};
   localparam logic signed [20:0] Q_LEFT  [6] = '{21'sd745578, 21'sd606081, 21'sd729202,
                                                  21'sd627239, 21'sd503674, 21'sd717899};
   localparam logic signed [20:0] Q_RIGHT [6] = '{-21'sd775022, -21'sd633863, -21'sd678901,
                                                  -21'sd612458, -21'sd455319, -21'sd692481};

   // The line test y*1e10 < s*(x*1e4 - t*2^18) is divided through by 16.
   localparam logic signed [31:0] LHS_K = 32'sd625000000;
   localparam logic signed [31:0] D_K   = 32'sd625;

endpackage
`default_nettype wire

@@ hdl/cff_ctrl.sv @@
// Sequencer of the calorimeter fiducial filter: accepts words, steps the edge arithmetic.
// Depends on cff_pkg; drives cff_datapath through cff_pkg::cmd_type.
`default_nettype none
module cff_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  cff_pkg::status_type status,
   output cff_pkg::cmd_type    cmd
);

   cff_pkg::state_type state_ff, state_in;
   logic [3:0]         step_ff, step_in;
   logic               accept;

   assign req_tready = (state_ff == cff_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd.load   = accept;
      cmd.calc   = (state_ff == cff_pkg::ST_CALC);
      cmd.step   = step_ff;
      cmd.commit = 1'b0;
      case (state_ff)
         cff_pkg::ST_IDLE: begin
            step_in = 4'd0;
            if (accept) begin
               state_in = status.need_edge ? cff_pkg::ST_CALC : cff_pkg::ST_DONE;
            end
         end
         cff_pkg::ST_CALC: begin
            step_in = step_ff + 4'd1;
            if (step_ff == cff_pkg::LAST_STEP) begin
               state_in = cff_pkg::ST_DONE;
            end
         end
         cff_pkg::ST_DONE: begin
            // A result waits here until the output register can take it.
            if (!status.item_end || status.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = cff_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cff_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cff_pkg::ST_IDLE;
         step_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == cff_pkg::ST_CALC |-> step_ff <= cff_pkg::LAST_STEP)
      else $error("edge step counter ran past its last step");
   a_edge_start: assert property (@(posedge clock) disable iff (reset)
      accept && status.need_edge |=> state_ff == cff_pkg::ST_CALC && step_ff == 4'd0)
      else $error("inner hit did not start the edge sequence");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == cff_pkg::ST_DONE && status.item_end && !status.slot_free
      |=> state_ff == cff_pkg::ST_DONE)
      else $error("result committed while output register was full");

endmodule
`default_nettype wire

@@ hdl/cff_datapath.sv @@
// Datapath of the calorimeter fiducial filter: item registers, shared multiplier,
// exclusion logic, particle state, configuration and output register. Depends on cff_pkg.
`default_nettype none
module cff_datapath #(
   parameter int NUM_LAYERS  = cff_pkg::NUM_LAYERS_DEF,
   parameter int NUM_SECTORS = cff_pkg::NUM_SECTORS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [cff_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire  [1:0]                       req_tuser,
   input  wire                              req_tlast,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [cff_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                              csr_we,
   input  wire                              csr_index,
   input  wire  [cff_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  cff_pkg::cmd_type                 cmd,
   output cff_pkg::status_type              status
);

   // Configuration.
   logic [1:0] mode_ff;
   logic       edge_en_ff;

   // Item registers.
   logic [1:0]         layer_ff;
   logic               present_ff, end_ff;
   logic [2:0]         sector_ff;
   logic [12:0]        u_ff, v_ff, w_ff;
   logic signed [13:0] x_ff, y_ff;

   // Particle state.
   logic            reject_ff, inner_seen_ff, edge_ok_ff;
   cff_pkg::cause_type cause_ff;
   logic [2:0]      inner_sector_ff;
   logic [1:0]      upper_seen_ff;

   // Edge arithmetic.
   logic signed [65:0] acc_ff, acc_in, lhs_ff, lhs_in;
   logic signed [29:0] xr_ff, xr_in, yr_ff, yr_in;
   logic signed [41:0] d_ff, d_in;
   logic               gt_ff, gt_in, lt_ff, lt_in, flag_ff, flag_in, edge_res_ff, edge_res_in;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod;
   logic signed [65:0] prod_x;
   logic signed [63:0] t1_x, t2_x;
   logic signed [31:0] coef1, coef2, d_hi, d_lo, x_x, y_x, xr_x, yr_x, cos_x, sin_x;
   logic signed [25:0] split;
   logic               sec_ok;
   logic [2:0]         k;

   // Output register.
   logic                           rsp_valid_ff;
   logic [cff_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   assign status.need_edge = (req_tuser == 2'd0) && req_tdata[0];
   assign status.item_end  = end_ff;
   assign status.slot_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 2'd0;
         edge_en_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == cff_pkg::CSR_EXCL_MODE) begin
            mode_ff <= csr_wdata[1:0];
         end else begin
            edge_en_ff <= csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         present_ff <= req_tdata[0];
         sector_ff  <= req_tdata[3:1];
         u_ff       <= req_tdata[16:4];
         v_ff       <= req_tdata[29:17];
         w_ff       <= req_tdata[42:30];
         x_ff       <= req_tdata[56:43];
         y_ff       <= req_tdata[70:57];
         layer_ff   <= req_tuser;
         end_ff     <= req_tlast;
      end
   end

   // Sectors outside the table use entry 0 and fail the test at the end.
   assign sec_ok = (sector_ff >= 3'd1) && (sector_ff <= 3'(NUM_SECTORS));
   assign k      = sec_ok ? sector_ff - 3'd1 : 3'd0;

   assign x_x   = 32'(x_ff);
   assign y_x   = 32'(y_ff);
   assign xr_x  = 32'(xr_ff);
   assign yr_x  = 32'(yr_ff);
   assign cos_x = 32'(cff_pkg::ROT_COS[k]);
   assign sin_x = 32'(cff_pkg::ROT_SIN[k]);
   assign split = $signed({1'b0, cff_pkg::P_SPLIT[k], 18'd0});
   assign coef1 = gt_ff ? 32'(cff_pkg::S_LEFT[k])  : 32'(cff_pkg::Q_LEFT[k]);
   assign coef2 = gt_ff ? 32'(cff_pkg::S_RIGHT[k]) : 32'(cff_pkg::Q_RIGHT[k]);
   assign t1_x  = $signed({30'd0, (gt_ff ? cff_pkg::T_LEFT[k]  : cff_pkg::R_LEFT[k]),  14'd0});
   assign t2_x  = $signed({30'd0, (gt_ff ? cff_pkg::T_RIGHT[k] : cff_pkg::R_RIGHT[k]), 14'd0});
   // The offset term is split into a signed high part and an unsigned low part.
   assign d_hi  = 32'($signed(d_ff[41:20]));
   assign d_lo  = $signed({12'd0, d_ff[19:0]});

   assign prod   = mul_a * mul_b;
   assign prod_x = 66'(prod);

   always_comb begin
      mul_a       = 32'sd0;
      mul_b       = 32'sd0;
      acc_in      = acc_ff;
      lhs_in      = lhs_ff;
      xr_in       = xr_ff;
      yr_in       = yr_ff;
      d_in        = d_ff;
      gt_in       = gt_ff;
      lt_in       = lt_ff;
      flag_in     = flag_ff;
      edge_res_in = edge_res_ff;
      case (cmd.step)
         4'd0: begin
            mul_a  = x_x;
            mul_b  = cos_x;
            acc_in = prod_x;
         end
         4'd1: begin
            mul_a = y_x;
            mul_b = sin_x;
            xr_in = 30'(acc_ff - prod_x);
         end
         4'd2: begin
            mul_a  = x_x;
            mul_b  = sin_x;
            acc_in = prod_x;
         end
         4'd3: begin
            mul_a = y_x;
            mul_b = cos_x;
            yr_in = 30'(acc_ff + prod_x);
         end
         4'd4: begin
            mul_a  = yr_x;
            mul_b  = cff_pkg::LHS_K;
            lhs_in = prod_x;
            gt_in  = xr_ff > 30'(split);
            lt_in  = xr_ff < 30'(split);
         end
         4'd5: begin
            mul_a = xr_x;
            mul_b = cff_pkg::D_K;
            d_in  = 42'(prod - t1_x);
         end
         4'd6: begin
            mul_a  = coef1;
            mul_b  = d_hi;
            acc_in = prod_x <<< 20;
         end
         4'd7: begin
            mul_a  = coef1;
            mul_b  = d_lo;
            acc_in = acc_ff + prod_x;
         end
         4'd8: begin
            flag_in = lhs_ff < acc_ff;
            mul_a   = xr_x;
            mul_b   = cff_pkg::D_K;
            d_in    = 42'(prod - t2_x);
         end
         4'd9: begin
            mul_a  = coef2;
            mul_b  = d_hi;
            acc_in = prod_x <<< 20;
         end
         4'd10: begin
            mul_a  = coef2;
            mul_b  = d_lo;
            acc_in = acc_ff + prod_x;
         end
         4'd11: begin
            // A point exactly on the split line fails.
            edge_res_in = sec_ok && (gt_ff || lt_ff) && flag_ff && (lhs_ff > acc_ff);
         end
         default: begin
            edge_res_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         acc_ff      <= acc_in;
         lhs_ff      <= lhs_in;
         xr_ff       <= xr_in;
         yr_ff       <= yr_in;
         d_ff        <= d_in;
         gt_ff       <= gt_in;
         lt_ff       <= lt_in;
         flag_ff     <= flag_in;
         edge_res_ff <= edge_res_in;
      end
   end

   // Per-item update and decision, applied on commit.
   logic               valid_layer, inner_hit;
   logic               inner_seen_n, edge_ok_n, reject_n, excl_hit, miss_lower, miss_end;
   logic [2:0]         inner_sector_n, seen;
   logic [1:0]         upper_seen_n;
   cff_pkg::cause_type cause_n, item_cause;
   logic [12:0]        coord_val;
   logic               rsp_acc;
   cff_pkg::cause_type rsp_cause;

   always_comb begin
      valid_layer    = layer_ff < 2'(NUM_LAYERS);
      inner_hit      = valid_layer && present_ff && (layer_ff == 2'd0);
      inner_seen_n   = inner_seen_ff || inner_hit;
      inner_sector_n = inner_hit ? sector_ff : inner_sector_ff;
      edge_ok_n      = inner_hit ? edge_res_ff : edge_ok_ff;
      upper_seen_n   = upper_seen_ff;
      if (valid_layer && present_ff && layer_ff == 2'd1) begin
         upper_seen_n[0] = 1'b1;
      end
      if (valid_layer && present_ff && layer_ff == 2'd2) begin
         upper_seen_n[1] = 1'b1;
      end
      seen = {upper_seen_n, inner_seen_n};

      miss_lower = 1'b0;
      for (int j = 0; j < cff_pkg::MAX_LAYERS; j++) begin
         if (2'(j) < layer_ff && !seen[j]) begin
            miss_lower = 1'b1;
         end
      end

      excl_hit = 1'b0;
      for (int e = 0; e < cff_pkg::EXCL_COUNT; e++) begin
         case (cff_pkg::EXCL_TABLE[e].coord)
            2'd0:    coord_val = u_ff;
            2'd1:    coord_val = v_ff;
            default: coord_val = w_ff;
         endcase
         if (cff_pkg::EXCL_TABLE[e].modes[mode_ff] &&
             cff_pkg::EXCL_TABLE[e].layer == layer_ff &&
             cff_pkg::EXCL_TABLE[e].sector == inner_sector_n &&
             coord_val >= cff_pkg::EXCL_TABLE[e].lo &&
             coord_val <= cff_pkg::EXCL_TABLE[e].hi) begin
            excl_hit = 1'b1;
         end
      end

      // The first failing check of the item decides its cause.
      if (miss_lower || !present_ff) begin
         item_cause = cff_pkg::CAUSE_MISSING;
      end else if (layer_ff == 2'd0 &&
                   (v_ff < cff_pkg::LOW_VW_LIMIT || w_ff < cff_pkg::LOW_VW_LIMIT)) begin
         item_cause = cff_pkg::CAUSE_LOW_VW;
      end else if (excl_hit) begin
         item_cause = cff_pkg::CAUSE_EXCLUDED;
      end else begin
         item_cause = cff_pkg::CAUSE_NONE;
      end

      reject_n = reject_ff;
      cause_n  = cause_ff;
      if (valid_layer && mode_ff != 2'd0 && item_cause != cff_pkg::CAUSE_NONE && !reject_n) begin
         reject_n = 1'b1;
         cause_n  = item_cause;
      end

      miss_end = 1'b0;
      for (int j = 0; j < cff_pkg::MAX_LAYERS; j++) begin
         if (j < NUM_LAYERS && !seen[j]) begin
            miss_end = 1'b1;
         end
      end
      if (end_ff && mode_ff != 2'd0 && miss_end && !reject_n) begin
         reject_n = 1'b1;
         cause_n  = cff_pkg::CAUSE_MISSING;
      end

      if (reject_n) begin
         rsp_acc   = 1'b0;
         rsp_cause = cause_n;
      end else if (edge_en_ff && !inner_seen_n) begin
         rsp_acc   = 1'b0;
         rsp_cause = cff_pkg::CAUSE_MISSING;
      end else if (edge_en_ff && !edge_ok_n) begin
         rsp_acc   = 1'b0;
         rsp_cause = cff_pkg::CAUSE_EDGE;
      end else begin
         rsp_acc   = 1'b1;
         rsp_cause = cff_pkg::CAUSE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reject_ff       <= 1'b0;
         cause_ff        <= cff_pkg::CAUSE_NONE;
         inner_sector_ff <= 3'd0;
         inner_seen_ff   <= 1'b0;
         edge_ok_ff      <= 1'b0;
         upper_seen_ff   <= 2'd0;
      end else if (cmd.commit) begin
         if (end_ff) begin
            reject_ff       <= 1'b0;
            cause_ff        <= cff_pkg::CAUSE_NONE;
            inner_sector_ff <= 3'd0;
            inner_seen_ff   <= 1'b0;
            edge_ok_ff      <= 1'b0;
            upper_seen_ff   <= 2'd0;
         end else begin
            reject_ff       <= reject_n;
            cause_ff        <= cause_n;
            inner_sector_ff <= inner_sector_n;
            inner_seen_ff   <= inner_seen_n;
            edge_ok_ff      <= edge_ok_n;
            upper_seen_ff   <= upper_seen_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && end_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && end_ff) begin
         rsp_data_ff <= {4'd0, rsp_cause, rsp_acc};
      end
   end

endmodule
`default_nettype wire

@@ hdl/calorimeter_fiducial_filter.sv @@
// Calorimeter fiducial filter. An item with an inner-layer hit runs the edge test between
// acceptance and commit, in twelve steps through one shared 32x32 multiplier; any other
// item goes straight to commit. One item is in work at a time: a new word is taken only
// once the previous one is committed; a result may wait in the output register meanwhile.
// Reset is synchronous and active high; it clears the sequencer, particle state and both
// configuration registers.
// Depends on cff_pkg, cff_ctrl and cff_datapath.
`default_nettype none
module calorimeter_fiducial_filter #(
   parameter int NUM_LAYERS  = cff_pkg::NUM_LAYERS_DEF,
   parameter int NUM_SECTORS = cff_pkg::NUM_SECTORS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // layer_present[0], hit_sector[3:1], strip_u[16:4], strip_v[29:17], strip_w[42:30],
   // pos_x[56:43], pos_y[70:57]
   input  wire  [cff_pkg::REQ_DATA_W-1:0] req_tdata,
   // layer_index[1:0]
   input  wire  [1:0]                     req_tuser,
   // end_of_particle
   input  wire                            req_tlast,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // accepted[0], reject_cause[3:1]
   output logic [cff_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire                            csr_we,
   input  wire                            csr_index,
   input  wire  [cff_pkg::CSR_DATA_W-1:0] csr_wdata
);

   cff_pkg::cmd_type    cmd;
   cff_pkg::status_type status;

   cff_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cff_datapath #(
      .NUM_LAYERS  (NUM_LAYERS),
      .NUM_SECTORS (NUM_SECTORS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for calorimeter_fiducial_filter: random and directed particles,
// checked against an in-bench predictor of the exclusion and sector edge cuts.
// Depends on hdl/cff_pkg.sv and the RTL of the filter.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   typedef struct {
      bit [1:0]         layer;
      bit               present;
      bit [2:0]         sector;
      bit [12:0]        u, v, w;
      bit signed [13:0] x, y;
      bit               last;
   } hit_word_type;

   class fiducial_scoreboard;
      bit [1:0] excl_mode;
      bit       edge_en;
      bit       rej;
      bit [2:0] rej_cause;
      bit [2:0] inner_sec;
      bit       inner_hit;
      bit       edge_good;
      bit [1:0] upper_hits;
      bit [3:0] verdicts[$];
      int       errors;
      int       results;
      // modes, layer, sector, coordinate (0 u, 1 v, 2 w), low, high
      int excl [18][6] = '{
         '{6, 0, 1, 2, 1152, 1512}, '{6, 0, 1, 2, 3528, 3744}, '{6, 0, 2, 1, 1584, 1872},
         '{4, 0, 2, 1, 504, 792},   '{6, 0, 3, 2, 5544, 6048}, '{6, 0, 4, 2, 0, 216},
         '{6, 0, 4, 1, 3672, 3888}, '{6, 0, 6, 2, 2664, 3096}, '{6, 1, 1, 1, 1080, 1512},
         '{6, 1, 5, 1, 0, 376},     '{6, 2, 1, 1, 0, 648},     '{6, 2, 5, 0, 3096, 3456},
         '{8, 0, 1, 2, 1152, 1512}, '{8, 0, 1, 2, 3312, 3744}, '{8, 0, 2, 1, 1584, 1800},
         '{8, 0, 3, 1, 5544, 6120}, '{8, 0, 4, 1, 3672, 3888}, '{8, 0, 6, 2, 2736, 3096}};
      longint cq[6]  = '{16384, 8192, -8192, -16384, -8192, 8192};
      longint sq[6]  = '{0, -14189, -14189, 0, 14189, 14189};
      longint spl[6] = '{87, 82, 85, 77, 78, 82};
      longint tl[6]  = '{587356, 628204, 622296, 537756, 582888, 545822};
      longint tr[6]  = '{587477, 512589, 592357, 562415, 608219, 498914};
      longint sl[6]  = '{582053, 544976, 549788, 568990, 564140, 573430};
      longint sr[6]  = '{-591876, -562926, -562246, -563726, -568902, -550729};
      longint rl[6]  = '{649348, 647541, 678320, 559324, 559225, 600997};
      longint rr[6]  = '{654240, 546992, 636628, 578931, 565367, 564641};
      longint ql[6]  = '{745578, 606081, 729202, 627239, 503674, 717899};
      longint qr[6]  = '{-775022, -633863, -678901, -612458, -455319, -692481};

      function void clear_particle();
         rej = 0; rej_cause = cff_pkg::CAUSE_NONE; inner_sec = 0;
         inner_hit = 0; edge_good = 0; upper_hits = 0;
      endfunction

      function bit in_range(int lay, int sec, int crd, int val);
         for (int i = 0; i < 18; i++)
            if (excl[i][0][excl_mode] && excl[i][1] == lay && excl[i][2] == sec &&
                excl[i][3] == crd && val >= excl[i][4] && val <= excl[i][5])
               return 1;
         return 0;
      endfunction

      function bit edge_inside(int sec, longint x, longint y);
         longint xr, yr, lhs, xs, split;
         int k;
         if (sec < 1 || sec > 6) return 0;
         k = sec - 1;
         xr = x * cq[k] - y * sq[k];
         yr = x * sq[k] + y * cq[k];
         split = spl[k] * 262144;
         lhs = yr * 64'sd10000000000;
         xs = xr * 10000;
         if (xr > split)
            return lhs < sl[k] * (xs - tl[k] * 262144) && lhs > sr[k] * (xs - tr[k] * 262144);
         if (xr < split)
            return lhs < ql[k] * (xs - rl[k] * 262144) && lhs > qr[k] * (xs - rr[k] * 262144);
         return 0;
      endfunction

      function void latch(bit [2:0] c);
         if (!rej) begin
            rej = 1; rej_cause = c;
         end
      endfunction

      function void note_word(hit_word_type h);
         bit [2:0] seen;
         if (h.layer < 3 && h.present) begin
            if (h.layer == 0) begin
               inner_hit = 1;
               inner_sec = h.sector;
               edge_good = edge_inside(h.sector, h.x, h.y);
            end else begin
               upper_hits[h.layer - 1] = 1;
            end
         end
         if (h.layer < 3 && excl_mode != 0) begin
            seen = {upper_hits, inner_hit};
            for (int j = 0; j < h.layer; j++)
               if (!seen[j]) latch(cff_pkg::CAUSE_MISSING);
            if (!h.present) latch(cff_pkg::CAUSE_MISSING);
            if (h.layer == 0 && h.present && (h.v < 144 || h.w < 144))
               latch(cff_pkg::CAUSE_LOW_VW);
            if (h.present && (in_range(h.layer, inner_sec, 0, h.u) ||
                              in_range(h.layer, inner_sec, 1, h.v) ||
                              in_range(h.layer, inner_sec, 2, h.w)))
               latch(cff_pkg::CAUSE_EXCLUDED);
         end
         if (!h.last) return;
         if (excl_mode != 0) begin
            seen = {upper_hits, inner_hit};
            for (int j = 0; j < 3; j++)
               if (!seen[j]) latch(cff_pkg::CAUSE_MISSING);
         end
         if (rej) verdicts.push_back({rej_cause, 1'b0});
         else if (edge_en && !inner_hit) verdicts.push_back({cff_pkg::CAUSE_MISSING, 1'b0});
         else if (edge_en && !edge_good) verdicts.push_back({cff_pkg::CAUSE_EDGE, 1'b0});
         else verdicts.push_back({cff_pkg::CAUSE_NONE, 1'b1});
         clear_particle();
      endfunction

      function void check_word(bit [7:0] d);
         bit [3:0] want;
         results++;
         if (verdicts.size() == 0) begin
            $display("%0t: unexpected result word: expected none, actual accepted=%0d cause=%0d",
                     $time, d[0], d[3:1]);
            errors++;
            return;
         end
         want = verdicts.pop_front();
         if (d[0] !== want[0]) begin
            $display("%0t: accepted mismatch: expected %0d, actual %0d", $time, want[0], d[0]);
            errors++;
         end
         if (d[3:1] !== want[3:1]) begin
            $display("%0t: reject_cause mismatch: expected %0d, actual %0d",
                     $time, want[3:1], d[3:1]);
            errors++;
         end
      endfunction
   endclass

   logic                           clock = 0;
   logic                           reset = 1;
   logic                           req_tvalid = 0;
   logic                           req_tready;
   logic [cff_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]                     req_tuser = '0;
   logic                           req_tlast = 0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 0;
   logic [cff_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_we = 0;
   logic                           csr_index = cff_pkg::CSR_EXCL_MODE;
   logic [cff_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   fiducial_scoreboard sb = new();
   int  send_idle_pct, recv_stall_pct;
   int  cycles = 0;
   int  words_sent = 0;
   bit  edge_on_seen = 0;

   calorimeter_fiducial_filter u_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 800000) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_word(hit_word_type h);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= h.layer;
      req_tlast  <= h.last;
      req_tdata  <= {1'b0, h.y, h.x, h.w, h.v, h.u, h.sector, h.present};
      do @(posedge clock); while (!req_tready);
      sb.note_word(h);
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.verdicts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(bit idx, bit [1:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic set_mode(bit [1:0] m, bit e);
      drain();
      write_csr(cff_pkg::CSR_EXCL_MODE, m);
      write_csr(cff_pkg::CSR_EDGE_EN, {1'b0, e});
      sb.excl_mode = m;
      sb.edge_en = e;
      if (e) edge_on_seen = 1;
   endtask

   // Coordinates cluster near the exclusion range borders and the low v/w limit.
   function automatic bit [12:0] pick_coord();
      int i, lo, hi;
      case ($urandom_range(3))
         0: return 13'($urandom_range(8191));
         1: return 13'($urandom_range(150, 7000));
         2: return 13'($urandom_range(130, 160));
         default: begin
            i = $urandom_range(17);
            lo = sb.excl[i][4];
            hi = sb.excl[i][5];
            return 13'($urandom_range(lo > 2 ? lo - 2 : 0, hi + 2));
         end
      endcase
   endfunction

   // A position built in the sector-1 frame and rotated back into the hit's sector.
   task automatic pick_position(int sec, output bit signed [13:0] x, y);
      longint xr, yr, px, py;
      int k;
      k = (sec >= 1 && sec <= 6) ? sec - 1 : 0;
      xr = $urandom_range(800, 6000);
      yr = longint'($urandom_range(0, 2 * xr)) - xr;
      px = (xr * sb.cq[k] + yr * sb.sq[k]) / 16384;
      py = (yr * sb.cq[k] - xr * sb.sq[k]) / 16384;
      if (px > 8191) px = 8191;
      if (px < -8192) px = -8192;
      if (py > 8191) py = 8191;
      if (py < -8192) py = -8192;
      x = 14'(px); y = 14'(py);
   endtask

   task automatic random_hit(output hit_word_type h, input int lay, input int sec,
                             input bit last);
      h.layer = 2'(lay);
      h.present = ($urandom_range(19) != 0);
      h.sector = 3'(sec);
      h.u = pick_coord(); h.v = pick_coord(); h.w = pick_coord();
      if ($urandom_range(4) == 0) begin
         h.x = 14'($urandom); h.y = 14'($urandom);
      end else begin
         pick_position(sec, h.x, h.y);
      end
      h.last = last;
   endtask

   task automatic send_particle();
      hit_word_type h;
      int sec, n;
      sec = ($urandom_range(15) == 0) ? $urandom_range(7) : $urandom_range(1, 6);
      if ($urandom_range(9) < 8) begin
         for (int l = 0; l < 3; l++) begin
            random_hit(h, l, sec, l == 2);
            send_word(h);
         end
      end else begin
         // Broken particle: random layers, length and order.
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            random_hit(h, $urandom_range(3), $urandom_range(7), i == n - 1);
            h.present = 1'($urandom);
            send_word(h);
         end
      end
   endtask

   task automatic directed_hit(int lay, bit pres, int sec, int u, int v, int w,
                               int x, int y, bit last);
      hit_word_type h;
      h.layer = 2'(lay); h.present = pres; h.sector = 3'(sec);
      h.u = 13'(u); h.v = 13'(v); h.w = 13'(w); h.x = 14'(x); h.y = 14'(y); h.last = last;
      send_word(h);
   endtask

   initial begin
      bit [1:0] modes [8] = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0};
      bit       edges [8] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
      send_idle_pct = 32;
      recv_stall_pct = 62;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      set_mode(2'd2, 1'b1);
      // Clean particle in sector 1, then extreme field values.
      directed_hit(0, 1, 1, 2000, 2000, 2000, 2400, 0, 0);
      directed_hit(1, 1, 1, 2000, 2000, 2000, 0, 0, 0);
      directed_hit(2, 1, 1, 2000, 2000, 2000, 0, 0, 1);
      directed_hit(0, 1, 7, 8191, 8191, 8191, 8191, 8191, 0);
      directed_hit(1, 1, 0, 0, 0, 0, -8192, -8192, 0);
      directed_hit(2, 1, 6, 8191, 0, 8191, 0, 0, 1);
      // Low v on the inner layer, then a later excluded strip that must not override it.
      directed_hit(0, 1, 1, 500, 143, 1200, 2400, 0, 0);
      directed_hit(1, 1, 1, 500, 1080, 500, 0, 0, 1);
      // Middle before inner, inner repeated, sector-2 extra v range of mode 2.
      directed_hit(1, 1, 2, 500, 500, 500, 0, 0, 0);
      directed_hit(0, 1, 2, 500, 504, 500, 1200, 2000, 0);
      directed_hit(0, 1, 2, 500, 792, 500, 1200, 2000, 1);
      // Outer-layer excluded range, then missing layers at the end.
      directed_hit(0, 1, 1, 500, 500, 500, 2400, 0, 0);
      directed_hit(1, 0, 1, 500, 500, 500, 0, 0, 0);
      directed_hit(2, 1, 1, 500, 648, 500, 0, 0, 1);
      directed_hit(3, 1, 1, 0, 0, 0, 0, 0, 1);
      // Point exactly on the sector-1 split line.
      directed_hit(0, 1, 1, 500, 500, 500, 1392, 0, 1);
      set_mode(2'd0, 1'b1);
      directed_hit(1, 1, 3, 500, 500, 500, 0, 0, 1);
      directed_hit(0, 1, 4, 500, 500, 500, -1200, -2000, 1);
      set_mode(2'd3, 1'b0);
      directed_hit(0, 1, 3, 500, 5544, 500, 0, 0, 0);
      directed_hit(1, 1, 3, 500, 500, 500, 0, 0, 0);
      directed_hit(2, 1, 3, 500, 500, 500, 0, 0, 1);
      for (int p = 0; p < 8; p++) begin
         if (p == 3) begin
            send_idle_pct = 62; recv_stall_pct = 32;
         end else if (p == 6) begin
            send_idle_pct = 0; recv_stall_pct = 0;
         end
         set_mode(modes[p], edges[p]);
         for (int i = 0; i < 70; i++) send_particle();
      end
      drain();
      $display("Sent %0d words and checked %0d results over all exclusion modes,", words_sent,
               sb.results);
      $display("edge cut on and off, with sender and receiver stalls in several patterns.");
      if (sb.errors == 0 && sb.verdicts.size() == 0 && edge_on_seen)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
hdl/cff_pkg.sv
hdl/cff_ctrl.sv
hdl/cff_datapath.sv
hdl/calorimeter_fiducial_filter.sv
sim/tb_top.sv
